@@ src/stq_pkg.sv @@
// Shared types, codes and constants of the sorted timer queue.
package stq_pkg;

	localparam int MS_PER_SECOND = 1000;
	localparam int SLOTS_DEFAULT = 16;
	localparam logic [23:0] DEFAULT_MAX_TIMEOUT = 24'(30 * MS_PER_SECOND);
	localparam logic [31:0] SIGN_BIT = 32'h8000_0000;

	// Command codes of an input item.
	typedef enum logic [1:0] {
		CMD_SCHEDULE = 2'd0,
		CMD_CANCEL   = 2'd1,
		CMD_TICK     = 2'd2,
		CMD_QUERY    = 2'd3
	} cmd_e_t;

	// Sequencer states.
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DISPATCH,
		ST_CANCEL,
		ST_SCAN,
		ST_DRAIN,
		ST_EVAL,
		ST_DONE
	} state_e_t;

	// One slot entry in the deadline memory.
	typedef struct packed {
		logic        notify;
		logic [31:0] deadline;
	} entry_t;

	// Memory access strobes and write data.
	typedef struct packed {
		logic   we;
		logic   re;
		entry_t wdata;
	} mem_req_t;

	// One result item.
	typedef struct packed {
		logic        status;
		logic        fired;
		logic [3:0]  fired_id;
		logic        cancel_notice;
		logic [23:0] timeout_ms;
		logic        is_scheduled;
	} result_t;

endpackage

@@ src/stq_if.sv @@
// Handshake interfaces for the command, result and configuration channels.
interface stq_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  cmd;
	logic [3:0]  timer_id;
	logic [23:0] delay_ms;
	logic        notify_on_cancel;

	modport source (output valid, cmd, timer_id, delay_ms, notify_on_cancel, input ready);
	modport sink (input valid, cmd, timer_id, delay_ms, notify_on_cancel, output ready);
endinterface

interface stq_rsp_if;
	logic        valid;
	logic        ready;
	logic        status;
	logic        fired;
	logic [3:0]  fired_id;
	logic        cancel_notice;
	logic [23:0] timeout_ms;
	logic        is_scheduled;

	modport source (output valid, status, fired, fired_id, cancel_notice, timeout_ms,
		is_scheduled, input ready);
	modport sink (input valid, status, fired, fired_id, cancel_notice, timeout_ms,
		is_scheduled, output ready);
endinterface

interface stq_cfg_if;
	logic        valid;
	logic        ready;
	logic [23:0] data;

	modport source (output valid, data, input ready);
	modport sink (input valid, data, output ready);
endinterface

@@ src/stq_mem.sv @@
// Deadline and notice-flag memory: one write port, one registered read port.
module stq_mem #(
	parameter int SLOTS = stq_pkg::SLOTS_DEFAULT,
	localparam int IW = $clog2(SLOTS)
) (
	input  logic             clk,
	input  stq_pkg::mem_req_t req,
	input  logic [IW-1:0]    waddr,
	input  logic [IW-1:0]    raddr,
	output stq_pkg::entry_t  rdata
);

	stq_pkg::entry_t mem_q [SLOTS];
	stq_pkg::entry_t rdata_q;

	// Write port.
	always_ff @(posedge clk) begin
		if (req.we) begin
			mem_q[waddr] <= req.wdata;
		end
	end

	// Registered read port.
	always_ff @(posedge clk) begin
		if (req.re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

@@ src/stq_ctrl.sv @@
// Command sequencer: slot bookkeeping, deadline scan and result register.
module stq_ctrl #(
	parameter int SLOTS = stq_pkg::SLOTS_DEFAULT,
	localparam int IW = $clog2(SLOTS)
) (
	input  logic              clk,
	input  logic              arst_n,
	stq_req_if.sink           req,
	stq_rsp_if.source         rsp,
	input  logic [23:0]       max_timeout_ms,
	output stq_pkg::mem_req_t mem_req,
	output logic [IW-1:0]     mem_waddr,
	output logic [IW-1:0]     mem_raddr,
	input  stq_pkg::entry_t   mem_rdata
);

	localparam logic [IW-1:0] LAST_SLOT = IW'(SLOTS - 1);

	stq_pkg::state_e_t state_q, state_d;
	stq_pkg::cmd_e_t   cmd_q;
	logic [3:0]        id_q;
	logic [23:0]       delay_q;
	logic              flag_q;
	logic [31:0]       now_q;
	logic [SLOTS-1:0]  busy_q;
	logic [IW-1:0]     cnt_q;
	logic              pipe_vld_s1;
	logic [IW-1:0]     pipe_idx_s1;
	logic              best_vld_q;
	logic [IW-1:0]     best_idx_q;
	logic [31:0]       best_key_q;
	stq_pkg::result_t  res_q, res_disp;
	stq_pkg::result_t  rsp_q;
	logic              rsp_valid_q;

	logic [IW-1:0] sid;
	logic          id_ok;
	logic          slot_busy;
	logic [31:0]   scan_key;
	logic          take;
	logic [31:0]   best_diff;
	logic          fire;
	logic [23:0]   timeout;
	logic          accept;
	logic          load_out;

	// Slot addressed by the current item and whether it names a real slot.
	assign sid       = IW'(id_q);
	assign id_ok     = 32'(id_q) < 32'(SLOTS);
	assign slot_busy = id_ok && busy_q[sid];

	assign accept   = (state_q == stq_pkg::ST_IDLE) && req.valid;
	assign load_out = (state_q == stq_pkg::ST_DONE) && (!rsp_valid_q || rsp.ready);

	// Scan compare: offset key of the entry read last cycle against the best so far.
	assign scan_key = (mem_rdata.deadline - now_q) ^ stq_pkg::SIGN_BIT;
	assign take     = pipe_vld_s1 && busy_q[pipe_idx_s1]
		&& (!best_vld_q || (scan_key < best_key_q));

	// Expiry and clamped timeout from the earliest slot.
	assign best_diff = best_key_q ^ stq_pkg::SIGN_BIT;
	assign fire      = best_vld_q && ((best_diff == 32'd0) || best_diff[31]);

	always_comb begin
		timeout = max_timeout_ms;
		if (best_vld_q) begin
			if (best_diff[31]) begin
				timeout = '0;
			end else if (best_diff < {8'd0, max_timeout_ms}) begin
				timeout = best_diff[23:0];
			end
		end
	end

	// Result fields known as soon as the command is decoded.
	always_comb begin
		res_disp = '0;
		unique case (cmd_q)
			stq_pkg::CMD_SCHEDULE: res_disp.status = !id_ok || slot_busy;
			stq_pkg::CMD_CANCEL:   res_disp.status = !slot_busy;
			stq_pkg::CMD_TICK:     res_disp.status = 1'b0;
			stq_pkg::CMD_QUERY:    res_disp.is_scheduled = slot_busy;
		endcase
	end

	// Next state and memory strobes.
	always_comb begin
		state_d       = state_q;
		mem_req       = '0;
		mem_req.wdata = '{notify: flag_q, deadline: now_q + 32'(delay_q)};
		mem_waddr     = sid;
		mem_raddr     = cnt_q;
		unique case (state_q)
			stq_pkg::ST_IDLE: begin
				if (req.valid) begin
					state_d = stq_pkg::ST_DISPATCH;
				end
			end
			stq_pkg::ST_DISPATCH: begin
				unique case (cmd_q)
					stq_pkg::CMD_SCHEDULE: begin
						mem_req.we = id_ok && !slot_busy;
						state_d    = stq_pkg::ST_DONE;
					end
					stq_pkg::CMD_CANCEL: begin
						if (slot_busy) begin
							mem_req.re = 1'b1;
							mem_raddr  = sid;
							state_d    = stq_pkg::ST_CANCEL;
						end else begin
							state_d = stq_pkg::ST_DONE;
						end
					end
					stq_pkg::CMD_TICK,
					stq_pkg::CMD_QUERY: state_d = stq_pkg::ST_SCAN;
				endcase
			end
			stq_pkg::ST_CANCEL: state_d = stq_pkg::ST_DONE;
			stq_pkg::ST_SCAN: begin
				mem_req.re = 1'b1;
				if (cnt_q == LAST_SLOT) begin
					state_d = stq_pkg::ST_DRAIN;
				end
			end
			stq_pkg::ST_DRAIN: state_d = stq_pkg::ST_EVAL;
			stq_pkg::ST_EVAL:  state_d = stq_pkg::ST_DONE;
			stq_pkg::ST_DONE: begin
				if (!rsp_valid_q || rsp.ready) begin
					state_d = stq_pkg::ST_IDLE;
				end
			end
			default: state_d = stq_pkg::ST_IDLE;
		endcase
	end

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= stq_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Control state: clock, busy bits, scan flags and result valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			now_q       <= '0;
			busy_q      <= '0;
			pipe_vld_s1 <= 1'b0;
			best_vld_q  <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			pipe_vld_s1 <= (state_q == stq_pkg::ST_SCAN);
			if (state_q == stq_pkg::ST_DISPATCH) begin
				best_vld_q <= 1'b0;
				unique case (cmd_q)
					stq_pkg::CMD_SCHEDULE: begin
						if (id_ok && !slot_busy) begin
							busy_q[sid] <= 1'b1;
						end
					end
					stq_pkg::CMD_CANCEL: begin
						if (slot_busy) begin
							busy_q[sid] <= 1'b0;
						end
					end
					stq_pkg::CMD_TICK:  now_q <= now_q + 32'd1;
					stq_pkg::CMD_QUERY: now_q <= now_q;
				endcase
			end else if (take) begin
				best_vld_q <= 1'b1;
			end
			if ((state_q == stq_pkg::ST_EVAL) && (cmd_q == stq_pkg::CMD_TICK) && fire) begin
				busy_q[best_idx_q] <= 1'b0;
			end
			if (load_out) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// Payload: captured item, scan pipeline, partial result and output register.
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q   <= stq_pkg::cmd_e_t'(req.cmd);
			id_q    <= req.timer_id;
			delay_q <= req.delay_ms;
			flag_q  <= req.notify_on_cancel;
		end
		if (state_q == stq_pkg::ST_DISPATCH) begin
			cnt_q <= '0;
			res_q <= res_disp;
		end else if (state_q == stq_pkg::ST_SCAN) begin
			cnt_q <= cnt_q + IW'(1);
		end
		pipe_idx_s1 <= cnt_q;
		if (take) begin
			best_idx_q <= pipe_idx_s1;
			best_key_q <= scan_key;
		end
		if (state_q == stq_pkg::ST_CANCEL) begin
			res_q.cancel_notice <= mem_rdata.notify;
		end
		if (state_q == stq_pkg::ST_EVAL) begin
			if (cmd_q == stq_pkg::CMD_TICK) begin
				res_q.fired    <= fire;
				res_q.fired_id <= fire ? 4'(best_idx_q) : 4'd0;
			end else begin
				res_q.timeout_ms <= timeout;
			end
		end
		if (load_out) begin
			rsp_q <= res_q;
		end
	end

	assign req.ready         = (state_q == stq_pkg::ST_IDLE);
	assign rsp.valid         = rsp_valid_q;
	assign rsp.status        = rsp_q.status;
	assign rsp.fired         = rsp_q.fired;
	assign rsp.fired_id      = rsp_q.fired_id;
	assign rsp.cancel_notice = rsp_q.cancel_notice;
	assign rsp.timeout_ms    = rsp_q.timeout_ms;
	assign rsp.is_scheduled  = rsp_q.is_scheduled;

endmodule

@@ src/sorted_timer_queue_top.sv @@
// Top level of the sorted timer queue: configuration register, sequencer and slot memory.
//
//   Channel  Direction  Payload
//   req      in         cmd, timer_id, delay_ms, notify_on_cancel
//   rsp      out        status, fired, fired_id, cancel_notice, timeout_ms, is_scheduled
//   cfg      in         data (max_timeout_ms)
//
// Schedule goes through dispatch and done; cancel adds a notice-flag read on a busy slot;
// tick and query scan every slot, reading one slot entry a cycle through the single read
// port of the slot memory, then drain and evaluate.
// Reset clears the clock and the slot busy flags at once; the memory needs no clearing.
// A finished result waits in the output register while the next item is accepted;
// an item completed behind a waiting result holds until that result is taken.
module sorted_timer_queue_top #(
	parameter int SLOTS = stq_pkg::SLOTS_DEFAULT
) (
	input  logic      clk,
	input  logic      arst_n,
	stq_req_if.sink   req,
	stq_rsp_if.source rsp,
	stq_cfg_if.sink   cfg
);

	localparam int IW = $clog2(SLOTS);

	logic [23:0]       max_timeout_q;
	stq_pkg::mem_req_t mem_req;
	logic [IW-1:0]     mem_waddr;
	logic [IW-1:0]     mem_raddr;
	stq_pkg::entry_t   mem_rdata;

	// Timeout clamp register, always ready for a write.
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_timeout_q <= stq_pkg::DEFAULT_MAX_TIMEOUT;
		end else if (cfg.valid) begin
			max_timeout_q <= cfg.data;
		end
	end

	stq_ctrl #(.SLOTS(SLOTS)) u_ctrl (
		.clk            (clk),
		.arst_n         (arst_n),
		.req            (req),
		.rsp            (rsp),
		.max_timeout_ms (max_timeout_q),
		.mem_req        (mem_req),
		.mem_waddr      (mem_waddr),
		.mem_raddr      (mem_raddr),
		.mem_rdata      (mem_rdata)
	);

	stq_mem #(.SLOTS(SLOTS)) u_mem (
		.clk   (clk),
		.req   (mem_req),
		.waddr (mem_waddr),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

endmodule

@@ src/stq_checker.sv @@
// Port-level checks of the sorted timer queue and their binding to the top level.
module stq_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        req_valid,
	input logic        req_ready,
	input logic        rsp_valid,
	input logic        rsp_ready,
	input logic        rsp_status,
	input logic        rsp_fired,
	input logic [3:0]  rsp_fired_id,
	input logic        rsp_cancel_notice,
	input logic [23:0] rsp_timeout_ms,
	input logic        rsp_is_scheduled,
	input logic        cfg_valid,
	input logic        cfg_ready,
	input logic [23:0] cfg_data
);

	logic [23:0] max_seen_q;

	// Track the clamp value written on the configuration channel.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_seen_q <= stq_pkg::DEFAULT_MAX_TIMEOUT;
		end else if (cfg_valid && cfg_ready) begin
			max_seen_q <= cfg_data;
		end
	end

	// A result offered and not taken is still offered in the next cycle.
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid)
		else $error("result withdrawn before it was taken");

	// The block works on one item at a time.
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("second item accepted while one is at work");

	// A fire carries no failure, notice or query flag; no fire reports slot zero.
	a_fire_fields: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (rsp_fired ? (!rsp_status && !rsp_cancel_notice && !rsp_is_scheduled)
			: (rsp_fired_id == 4'd0)))
		else $error("inconsistent fire fields");

	// Reported timeout never exceeds the clamp, and notices only follow success.
	a_timeout_clamp: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (rsp_timeout_ms <= max_seen_q) && !(rsp_cancel_notice && rsp_status))
		else $error("timeout above clamp or notice on failed cancel");

endmodule

bind sorted_timer_queue_top stq_checker u_stq_checker (
	.clk               (clk),
	.arst_n            (arst_n),
	.req_valid         (req.valid),
	.req_ready         (req.ready),
	.rsp_valid         (rsp.valid),
	.rsp_ready         (rsp.ready),
	.rsp_status        (rsp.status),
	.rsp_fired         (rsp.fired),
	.rsp_fired_id      (rsp.fired_id),
	.rsp_cancel_notice (rsp.cancel_notice),
	.rsp_timeout_ms    (rsp.timeout_ms),
	.rsp_is_scheduled  (rsp.is_scheduled),
	.cfg_valid         (cfg.valid),
	.cfg_ready         (cfg.ready),
	.cfg_data          (cfg.data)
);
